@@ rtl/core/sdu_pkg.sv @@
// ----------------------------------------------------------------------------
// SSE diagonal update package
// Shared types and codes for the diagonal-update front end, back end and
// the top level.
// ----------------------------------------------------------------------------
package sdu_pkg;

  typedef enum logic [2:0] {
    ACT_SLOT   = 3'd0,
    ACT_SPIN   = 3'd1,
    ACT_ALIAS  = 3'd2,
    ACT_WEIGHT = 3'd3,
    ACT_RECIP  = 3'd4,
    ACT_ENDS   = 3'd5,
    ACT_COUNT  = 3'd6,
    ACT_NONE   = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    K_WRITE,
    K_FLIP,
    K_DIAG,
    K_IDENT
  } kind_t;

  typedef enum logic [2:0] {
    OUT_KEPT    = 3'd0,
    OUT_REMOVED = 3'd1,
    OUT_SITE    = 3'd2,
    OUT_BOND    = 3'd3,
    OUT_WRITE   = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    REG_STRING_LENGTH = 2'd0,
    REG_BETA_NORM     = 2'd1,
    REG_INV_BETA_NORM = 2'd2,
    REG_ALIAS_COUNT   = 2'd3
  } reg_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FLIP, S_A1, S_A2, S_A3, S_B1, S_B2, S_B3, S_B4, S_OUT
  } state_t;

  localparam logic signed [2:0]  OP_OFFDIAG = -3'sd1;
  localparam logic signed [2:0]  OP_IDENT   = 3'sd0;
  localparam logic signed [2:0]  OP_SITE    = 3'sd1;
  localparam logic signed [2:0]  OP_BOND    = 3'sd2;
  localparam logic signed [12:0] LOC_NONE   = -13'sd1;

  typedef struct packed {
    logic [15:0] string_length;
    logic [39:0] beta_norm;
    logic [39:0] inv_beta_norm;
    logic [13:0] alias_count;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    act_t              action;
    logic signed [2:0] op_type;
    logic [11:0]       op_loc;
    logic [13:0]       entry_index;
    logic [31:0]       entry_value;
    logic [12:0]       entry_ref_a;
    logic [12:0]       entry_ref_b;
    logic [12:0]       tgt_quot;
    logic [31:0]       rand_remove;
    logic [31:0]       rand_insert;
    logic [31:0]       rand_pick;
    logic [31:0]       rand_alias;
    logic [31:0]       rand_bond;
  } item_t;

endpackage

@@ rtl/core/sdu_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ rtl/core/sdu_front.sv @@
// ----------------------------------------------------------------------------
// SSE diagonal update front end
// Accepts words, classifies them and queues them for the back end. The
// alias-target quotient for the modulo reduction is formed here.
// ----------------------------------------------------------------------------
module sdu_front #(
  parameter int MAX_ALIAS = 8192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_action,
  input  logic signed [2:0]   in_op_type,
  input  logic [11:0]         in_op_loc,
  input  logic [13:0]         in_entry_index,
  input  logic [31:0]         in_entry_value,
  input  logic [12:0]         in_entry_ref_a,
  input  logic [12:0]         in_entry_ref_b,
  input  logic [31:0]         in_rand_remove,
  input  logic [31:0]         in_rand_insert,
  input  logic [31:0]         in_rand_pick,
  input  logic [31:0]         in_rand_alias,
  input  logic [31:0]         in_rand_bond,
  input  logic                clearing,
  output sdu_pkg::item_t      head,
  output logic                head_valid,
  input  logic                pop
);

  // Rounded-up reciprocal; exact floor division for any 13-bit target.
  localparam logic [40:0] MOD_RECIP = ((41'd1 << 40) + 41'(MAX_ALIAS) - 41'd1) / 41'(MAX_ALIAS);

  sdu_pkg::item_t fifo_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic [53:0]    quot_prod;
  sdu_pkg::item_t item;

  assign in_stall   = (cnt_r == 2'd2) || clearing;
  assign push       = in_valid && !in_stall;
  assign head       = fifo_r[rp_r];
  assign head_valid = (cnt_r != 2'd0);
  assign quot_prod  = 54'(in_entry_ref_a) * 54'(MOD_RECIP);

  always_comb begin
    item.action      = sdu_pkg::act_t'(in_action);
    item.op_type     = in_op_type;
    item.op_loc      = in_op_loc;
    item.entry_index = in_entry_index;
    item.entry_value = in_entry_value;
    item.entry_ref_a = in_entry_ref_a;
    item.entry_ref_b = in_entry_ref_b;
    item.tgt_quot    = quot_prod[52:40];
    item.rand_remove = in_rand_remove;
    item.rand_insert = in_rand_insert;
    item.rand_pick   = in_rand_pick;
    item.rand_alias  = in_rand_alias;
    item.rand_bond   = in_rand_bond;
    // Unknown operator codes are treated as identity slots.
    if (in_action != sdu_pkg::ACT_SLOT) begin
      item.kind = sdu_pkg::K_WRITE;
    end else if (in_op_type == sdu_pkg::OP_OFFDIAG) begin
      item.kind = sdu_pkg::K_FLIP;
    end else if (in_op_type == sdu_pkg::OP_SITE || in_op_type == sdu_pkg::OP_BOND) begin
      item.kind = sdu_pkg::K_DIAG;
    end else begin
      item.kind = sdu_pkg::K_IDENT;
    end
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= item;
    end
  end

endmodule

@@ rtl/core/sdu_back.sv @@
// ----------------------------------------------------------------------------
// SSE diagonal update back end
// Sequencer that owns the tables and the operator count, carries out one
// queued word at a time and drives the registered result channel.
// ----------------------------------------------------------------------------
module sdu_back #(
  parameter int MAX_SITES = 1024,
  parameter int MAX_BONDS = 4096,
  parameter int MAX_ALIAS = 8192,
  parameter int MAX_SLOTS = 65535
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdu_pkg::cfg_t        cfg,
  input  sdu_pkg::item_t       head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 clearing,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [2:0]    out_new_op_type,
  output logic signed [12:0]   out_new_op_loc,
  output logic [15:0]          out_op_count,
  output logic [2:0]           out_outcome
);

  localparam int SAW = $clog2(MAX_SITES);
  localparam int BAW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;
  localparam int WAW = $clog2(MAX_BONDS * 4);
  localparam int AAW = $clog2(MAX_ALIAS);

  sdu_pkg::state_t    st_r, st_nxt;
  logic [SAW-1:0]     clr_r, clr_nxt;
  logic [15:0]        ops_r, ops_nxt;
  logic [SAW-1:0]     loc_r, loc_nxt;
  logic [AAW-1:0]     pick_r, pick_nxt;
  logic [31:0]        ralias_r, ralias_nxt, rbond_r, rbond_nxt;
  logic [BAW-1:0]     where_r, where_nxt;
  logic               ina_r, ina_nxt, inb_r, inb_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic signed [2:0]  res_type_r, res_type_nxt;
  logic signed [12:0] res_loc_r, res_loc_nxt;
  sdu_pkg::outcome_t  res_outc_r, res_outc_nxt;

  logic               out_free, emit;
  logic signed [2:0]  e_type;
  logic signed [12:0] e_loc;
  sdu_pkg::outcome_t  e_outc;

  // Table ports.
  logic               spin_we, spin_wd, spin_rd_a, spin_rd_b;
  logic [SAW-1:0]     spin_wa, spin_ra_a, spin_ra_b;
  logic               ap_we, lk_we, rc_we, en_we, wt_we;
  logic [32+AAW-1:0]  ap_rd;
  logic [12:0]        lk_rd;
  logic [31:0]        rc_rd, wt_rd;
  logic [25:0]        en_rd;
  logic [AAW-1:0]     idx;
  logic [BAW-1:0]     bond_ra;
  logic [WAW-1:0]     wt_ra;
  logic [11:0]        where_c;
  logic [1:0]         pat;
  logic [26:0]        tgt_prod;
  logic [12:0]        tgt_mod;

  // Slot arithmetic.
  logic [15:0]        m, free;
  logic signed [17:0] room;
  logic [56:0]        rem_prod;
  logic [47:0]        ins_prod;
  logic [13:0]        cnt;
  logic [45:0]        pick_prod;
  logic               rem_ok, ins_ok;

  assign out_free = !out_valid || !out_stall;
  assign clearing = (st_r == sdu_pkg::S_CLR);

  always_comb begin
    m    = (32'(cfg.string_length) < 32'(MAX_SLOTS)) ? cfg.string_length : 16'(MAX_SLOTS);
    room = $signed({2'b00, m}) - $signed({2'b00, ops_r}) + 18'sd1;
    rem_prod = 57'(room[16:0]) * 57'(cfg.inv_beta_norm);
    rem_ok   = !room[17] && (room != 18'sd0) && (57'(head.rand_remove) < rem_prod);
    free     = m - ops_r;
    ins_prod = 48'(head.rand_insert) * 48'(free);
    ins_ok   = (ops_r < m) && (56'(ins_prod) < {cfg.beta_norm, 16'h0000});
    if (cfg.alias_count == 14'd0) begin
      cnt = 14'd1;
    end else if (32'(cfg.alias_count) > 32'(MAX_ALIAS)) begin
      cnt = 14'(MAX_ALIAS);
    end else begin
      cnt = cfg.alias_count;
    end
    pick_prod = 46'(head.rand_pick) * 46'(cnt);
    tgt_prod  = 27'(head.tgt_quot) * 27'(MAX_ALIAS);
    tgt_mod   = head.entry_ref_a - tgt_prod[12:0];
  end

  // Read addresses follow the sequencer state.
  always_comb begin
    idx       = (ralias_r < ap_rd[32+AAW-1:AAW]) ? pick_r : ap_rd[AAW-1:0];
    where_c   = lk_rd[12:1];
    bond_ra   = (st_r == sdu_pkg::S_A3) ? where_c[BAW-1:0] : where_r;
    pat       = {spin_rd_a & ina_r, spin_rd_b & inb_r};
    wt_ra     = WAW'({where_r, pat});
    spin_ra_a = (st_r == sdu_pkg::S_B1) ? en_rd[SAW+12:13] : head.op_loc[SAW-1:0];
    spin_ra_b = en_rd[SAW-1:0];
  end

  always_comb begin
    st_nxt       = st_r;
    clr_nxt      = clr_r;
    ops_nxt      = ops_r;
    loc_nxt      = loc_r;
    pick_nxt     = pick_r;
    ralias_nxt   = ralias_r;
    rbond_nxt    = rbond_r;
    where_nxt    = where_r;
    ina_nxt      = ina_r;
    inb_nxt      = inb_r;
    acc_nxt      = acc_r;
    res_type_nxt = res_type_r;
    res_loc_nxt  = res_loc_r;
    res_outc_nxt = res_outc_r;
    pop          = 1'b0;
    emit         = 1'b0;
    e_type       = sdu_pkg::OP_IDENT;
    e_loc        = sdu_pkg::LOC_NONE;
    e_outc       = sdu_pkg::OUT_KEPT;
    spin_we      = 1'b0;
    spin_wa      = head.entry_index[SAW-1:0];
    spin_wd      = head.entry_value[0];
    ap_we        = 1'b0;
    lk_we        = 1'b0;
    rc_we        = 1'b0;
    en_we        = 1'b0;
    wt_we        = 1'b0;

    unique case (st_r)
      sdu_pkg::S_CLR: begin
        spin_we = 1'b1;
        spin_wa = clr_r;
        spin_wd = 1'b0;
        clr_nxt = clr_r + SAW'(1);
        if (32'(clr_r) == 32'(MAX_SITES - 1)) begin
          st_nxt = sdu_pkg::S_IDLE;
        end
      end
      sdu_pkg::S_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          unique case (head.kind)
            sdu_pkg::K_WRITE: begin
              case (head.action)
                sdu_pkg::ACT_SPIN:
                  spin_we = (32'(head.entry_index) < 32'(MAX_SITES));
                sdu_pkg::ACT_ALIAS: begin
                  ap_we = (32'(head.entry_index) < 32'(MAX_ALIAS));
                  lk_we = ap_we;
                end
                sdu_pkg::ACT_WEIGHT:
                  wt_we = (32'(head.entry_index) < 32'(MAX_BONDS * 4));
                sdu_pkg::ACT_RECIP:
                  rc_we = (32'(head.entry_index) < 32'(MAX_BONDS));
                sdu_pkg::ACT_ENDS:
                  en_we = (32'(head.entry_index) < 32'(MAX_BONDS));
                sdu_pkg::ACT_COUNT:
                  ops_nxt = head.entry_value[15:0];
                default: ;
              endcase
              emit   = 1'b1;
              e_outc = sdu_pkg::OUT_WRITE;
            end
            sdu_pkg::K_FLIP: begin
              if (32'(head.op_loc) < 32'(MAX_SITES)) begin
                loc_nxt      = head.op_loc[SAW-1:0];
                res_type_nxt = sdu_pkg::OP_OFFDIAG;
                res_loc_nxt  = $signed({1'b0, head.op_loc});
                res_outc_nxt = sdu_pkg::OUT_KEPT;
                st_nxt       = sdu_pkg::S_FLIP;
              end else begin
                emit   = 1'b1;
                e_type = sdu_pkg::OP_OFFDIAG;
                e_loc  = $signed({1'b0, head.op_loc});
              end
            end
            sdu_pkg::K_DIAG: begin
              emit = 1'b1;
              if (rem_ok) begin
                if (ops_r != 16'd0) begin
                  ops_nxt = ops_r - 16'd1;
                end
                e_outc = sdu_pkg::OUT_REMOVED;
              end else begin
                e_type = head.op_type;
                e_loc  = $signed({1'b0, head.op_loc});
              end
            end
            sdu_pkg::K_IDENT: begin
              if (ins_ok) begin
                pick_nxt   = pick_prod[32+AAW-1:32];
                ralias_nxt = head.rand_alias;
                rbond_nxt  = head.rand_bond;
                st_nxt     = sdu_pkg::S_A1;
              end else begin
                emit = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      sdu_pkg::S_FLIP: begin
        spin_we = 1'b1;
        spin_wa = loc_r;
        spin_wd = ~spin_rd_a;
        st_nxt  = sdu_pkg::S_OUT;
      end
      sdu_pkg::S_A1: st_nxt = sdu_pkg::S_A2;
      sdu_pkg::S_A2: st_nxt = sdu_pkg::S_A3;
      sdu_pkg::S_A3: begin
        st_nxt = sdu_pkg::S_OUT;
        if (!lk_rd[0]) begin
          ops_nxt      = ops_r + 16'd1;
          res_type_nxt = sdu_pkg::OP_SITE;
          res_loc_nxt  = $signed({1'b0, where_c});
          res_outc_nxt = sdu_pkg::OUT_SITE;
        end else if (32'(where_c) < 32'(MAX_BONDS)) begin
          where_nxt = where_c[BAW-1:0];
          st_nxt    = sdu_pkg::S_B1;
        end else begin
          res_type_nxt = sdu_pkg::OP_IDENT;
          res_loc_nxt  = sdu_pkg::LOC_NONE;
          res_outc_nxt = sdu_pkg::OUT_KEPT;
        end
      end
      sdu_pkg::S_B1: begin
        ina_nxt = (32'(en_rd[25:13]) < 32'(MAX_SITES));
        inb_nxt = (32'(en_rd[12:0]) < 32'(MAX_SITES));
        st_nxt  = sdu_pkg::S_B2;
      end
      sdu_pkg::S_B2: st_nxt = sdu_pkg::S_B3;
      sdu_pkg::S_B3: begin
        acc_nxt = 64'(wt_rd) * 64'(rc_rd);
        st_nxt  = sdu_pkg::S_B4;
      end
      sdu_pkg::S_B4: begin
        st_nxt = sdu_pkg::S_OUT;
        if (64'(rbond_r) < acc_r) begin
          ops_nxt      = ops_r + 16'd1;
          res_type_nxt = sdu_pkg::OP_BOND;
          res_loc_nxt  = $signed({1'b0, 12'(where_r)});
          res_outc_nxt = sdu_pkg::OUT_BOND;
        end else begin
          res_type_nxt = sdu_pkg::OP_IDENT;
          res_loc_nxt  = sdu_pkg::LOC_NONE;
          res_outc_nxt = sdu_pkg::OUT_KEPT;
        end
      end
      sdu_pkg::S_OUT: begin
        if (out_free) begin
          emit   = 1'b1;
          e_type = res_type_r;
          e_loc  = res_loc_r;
          e_outc = res_outc_r;
          st_nxt = sdu_pkg::S_IDLE;
        end
      end
      default: st_nxt = sdu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= sdu_pkg::S_CLR;
      clr_r     <= '0;
      ops_r     <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ops_r <= ops_nxt;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    loc_r      <= loc_nxt;
    pick_r     <= pick_nxt;
    ralias_r   <= ralias_nxt;
    rbond_r    <= rbond_nxt;
    where_r    <= where_nxt;
    ina_r      <= ina_nxt;
    inb_r      <= inb_nxt;
    acc_r      <= acc_nxt;
    res_type_r <= res_type_nxt;
    res_loc_r  <= res_loc_nxt;
    res_outc_r <= res_outc_nxt;
    if (emit) begin
      out_new_op_type <= e_type;
      out_new_op_loc  <= e_loc;
      out_op_count    <= ops_nxt;
      out_outcome     <= e_outc;
    end
  end

  // Two spin copies give the two endpoint reads of a bond in the same cycle.
  sdu_ram #(.WIDTH(1), .DEPTH(MAX_SITES)) u_spin_a (
    .clk(clk), .we(spin_we), .waddr(spin_wa), .wdata(spin_wd),
    .raddr(spin_ra_a), .rdata(spin_rd_a)
  );

  sdu_ram #(.WIDTH(1), .DEPTH(MAX_SITES)) u_spin_b (
    .clk(clk), .we(spin_we), .waddr(spin_wa), .wdata(spin_wd),
    .raddr(spin_ra_b), .rdata(spin_rd_b)
  );

  sdu_ram #(.WIDTH(32 + AAW), .DEPTH(MAX_ALIAS)) u_alias (
    .clk(clk), .we(ap_we), .waddr(head.entry_index[AAW-1:0]),
    .wdata({head.entry_value, tgt_mod[AAW-1:0]}),
    .raddr(pick_r), .rdata(ap_rd)
  );

  sdu_ram #(.WIDTH(13), .DEPTH(MAX_ALIAS)) u_loc_kind (
    .clk(clk), .we(lk_we), .waddr(head.entry_index[AAW-1:0]),
    .wdata(head.entry_ref_b), .raddr(idx), .rdata(lk_rd)
  );

  sdu_ram #(.WIDTH(32), .DEPTH(MAX_BONDS)) u_recip (
    .clk(clk), .we(rc_we), .waddr(head.entry_index[BAW-1:0]),
    .wdata(head.entry_value), .raddr(bond_ra), .rdata(rc_rd)
  );

  sdu_ram #(.WIDTH(26), .DEPTH(MAX_BONDS)) u_ends (
    .clk(clk), .we(en_we), .waddr(head.entry_index[BAW-1:0]),
    .wdata({head.entry_ref_a, head.entry_ref_b}), .raddr(bond_ra), .rdata(en_rd)
  );

  sdu_ram #(.WIDTH(32), .DEPTH(MAX_BONDS * 4)) u_weights (
    .clk(clk), .we(wt_we), .waddr(head.entry_index[WAW-1:0]),
    .wdata(head.entry_value), .raddr(wt_ra), .rdata(wt_rd)
  );

endmodule

@@ rtl/core/sse_diagonal_update_core.sv @@
// The result word is registered when the back end pops a table write, a diagonal slot
// or a skipped identity slot; an off-diagonal flip takes a spin read and write, a
// site insertion the alias entry and loc/kind reads, and a bond insertion the whole
// chain of registered table reads (alias entry, loc/kind, bond ends, spins, weight)
// and the weight product. Throughput is one word per back-end pass of the sequencer.
// Synchronous reset; afterwards the spins are cleared site by site, in_stall high.
// ----------------------------------------------------------------------------
// SSE diagonal update core
// Operator-string diagonal update with alias-table insertion, fed one slot
// or table-load word at a time.
// ----------------------------------------------------------------------------
module sse_diagonal_update_core #(
  parameter int MAX_SITES = 1024,
  parameter int MAX_BONDS = 4096,
  parameter int MAX_ALIAS = 8192,
  parameter int MAX_SLOTS = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [2:0]  in_op_type,
  input  logic [11:0]        in_op_loc,
  input  logic [13:0]        in_entry_index,
  input  logic [31:0]        in_entry_value,
  input  logic [12:0]        in_entry_ref_a,
  input  logic [12:0]        in_entry_ref_b,
  input  logic [31:0]        in_rand_remove,
  input  logic [31:0]        in_rand_insert,
  input  logic [31:0]        in_rand_pick,
  input  logic [31:0]        in_rand_alias,
  input  logic [31:0]        in_rand_bond,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [2:0]  out_new_op_type,
  output logic signed [12:0] out_new_op_loc,
  output logic [15:0]        out_op_count,
  output logic [2:0]         out_outcome
);

  sdu_pkg::cfg_t  cfg_r;
  sdu_pkg::item_t head;
  logic           head_valid, pop, clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.string_length <= 16'd20;
      cfg_r.beta_norm     <= 40'd0;
      cfg_r.inv_beta_norm <= 40'd0;
      cfg_r.alias_count   <= 14'd1;
    end else if (cfg_we) begin
      unique case (sdu_pkg::reg_t'(cfg_index))
        sdu_pkg::REG_STRING_LENGTH: cfg_r.string_length <= cfg_wdata[15:0];
        sdu_pkg::REG_BETA_NORM:     cfg_r.beta_norm     <= cfg_wdata;
        sdu_pkg::REG_INV_BETA_NORM: cfg_r.inv_beta_norm <= cfg_wdata;
        sdu_pkg::REG_ALIAS_COUNT:   cfg_r.alias_count   <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  sdu_front #(.MAX_ALIAS(MAX_ALIAS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_op_type(in_op_type), .in_op_loc(in_op_loc),
    .in_entry_index(in_entry_index), .in_entry_value(in_entry_value),
    .in_entry_ref_a(in_entry_ref_a), .in_entry_ref_b(in_entry_ref_b),
    .in_rand_remove(in_rand_remove), .in_rand_insert(in_rand_insert),
    .in_rand_pick(in_rand_pick), .in_rand_alias(in_rand_alias),
    .in_rand_bond(in_rand_bond),
    .clearing(clearing), .head(head), .head_valid(head_valid), .pop(pop)
  );

  sdu_back #(
    .MAX_SITES(MAX_SITES), .MAX_BONDS(MAX_BONDS),
    .MAX_ALIAS(MAX_ALIAS), .MAX_SLOTS(MAX_SLOTS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .head(head), .head_valid(head_valid), .pop(pop), .clearing(clearing),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_new_op_type(out_new_op_type), .out_new_op_loc(out_new_op_loc),
    .out_op_count(out_op_count), .out_outcome(out_outcome)
  );

endmodule

@@ rtl/core/sdu_checker.sv @@
// ----------------------------------------------------------------------------
// SSE diagonal update port checker
// Watches the result channel of the core for consistent result words.
// ----------------------------------------------------------------------------
module sdu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [2:0]  out_new_op_type,
  input logic signed [12:0] out_new_op_loc,
  input logic [15:0]        out_op_count,
  input logic [2:0]         out_outcome
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_op_type)
      && $stable(out_new_op_loc) && $stable(out_op_count) && $stable(out_outcome))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == sdu_pkg::OUT_WRITE || out_outcome == sdu_pkg::OUT_REMOVED)
      |-> out_new_op_type == sdu_pkg::OP_IDENT && out_new_op_loc == sdu_pkg::LOC_NONE)
    else $error("table write or removal word is not an identity");

  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == sdu_pkg::OUT_SITE
      |-> out_new_op_type == sdu_pkg::OP_SITE && !out_new_op_loc[12] && out_op_count != 16'd0)
    else $error("site insertion word inconsistent");

endmodule

bind sse_diagonal_update_core sdu_checker u_sdu_checker (.*);
